### sv/tsdh_pkg.sv
`timescale 1ns / 1ps
// tsdh_pkg: shared types, constants and a helper function for the transmit-slot
// duty and band hop unit; no dependencies
package tsdh_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_DUTY_PERCENT     = 3'd0;
  localparam logic [2:0] REG_HOP_ENABLE       = 3'd1;
  localparam logic [2:0] REG_HOP_PERIOD       = 3'd2;
  localparam logic [2:0] REG_BAND_ENABLE_MASK = 3'd3;
  localparam logic [2:0] REG_FALLBACK_BAND    = 3'd4;

  // reset values of the registers
  localparam logic [6:0]  DUTY_PERCENT_RST     = 7'd100;
  localparam logic        HOP_ENABLE_RST       = 1'b0;
  localparam logic [31:0] HOP_PERIOD_RST       = 32'd120;
  localparam logic [15:0] BAND_ENABLE_MASK_RST = 16'd32;
  localparam logic [3:0]  FALLBACK_BAND_RST    = 4'd5;

  // fixed constants
  localparam logic [31:0] HOP_INTERVAL_DEFAULT = 32'd120;
  localparam logic [6:0]  DUTY_FULL            = 7'd100;
  localparam logic [9:0]  CREDIT_WRAP          = 10'd100;
  localparam logic [9:0]  CREDIT_CAP           = 10'd200;

  typedef struct packed {
    logic [6:0]  duty_percent;
    logic        hop_enable;
    logic [31:0] hop_period;
    logic [15:0] band_enable_mask;
    logic [3:0]  fallback_band;
  } cfg_t;

  typedef struct packed {
    logic [3:0] band;
    logic       hopped;
    logic       used_fallback;
  } band_res_t;

  // index of the lowest set bit, 0 when none is set
  function automatic logic [3:0] lowest_band(input logic [15:0] set);
    logic [3:0] idx;
    logic       found;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (set[i] && !found) begin
        idx   = 4'(i);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

### sv/tsdh_duty.sv
`timescale 1ns / 1ps
// tsdh_duty: credit accumulator that decides whether a slot transmits
// depends on tsdh_pkg
module tsdh_duty import tsdh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [6:0] duty_i,
  output logic       tx_o
);

  logic       primed_q, primed_d;
  logic [8:0] credit_q, credit_d;
  logic [6:0] prev_q, prev_d;

  logic       chg;
  logic [9:0] cred0, cred1, cred2, sum;

  always_comb begin
    chg   = (duty_i != prev_q);
    cred0 = chg ? 10'd0 : {1'b0, credit_q};
    cred1 = cred0;
    // priming on first slot or after a duty change
    if (!(primed_q && !chg)) begin
      if (duty_i != 7'd0 && duty_i < DUTY_FULL) begin
        cred1 = CREDIT_WRAP - 10'(duty_i);
      end else if (duty_i >= DUTY_FULL) begin
        cred1 = 10'd0;
      end
    end
    sum  = cred1 + 10'(duty_i);
    tx_o = 1'b0;
    cred2 = cred1;
    if (duty_i >= DUTY_FULL) begin
      tx_o = 1'b1;
    end else if (duty_i != 7'd0) begin
      if (sum >= CREDIT_WRAP) begin
        cred2 = sum - CREDIT_WRAP;
        tx_o  = 1'b1;
      end else begin
        cred2 = sum;
      end
    end
    // clamp after a skip
    if (!tx_o && cred2 > CREDIT_CAP) begin
      cred2 = CREDIT_CAP;
    end
    credit_d = cred2[8:0];
    primed_d = 1'b1;
    prev_d   = duty_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      credit_q <= '0;
      prev_q   <= '0;
    end else if (adv_i) begin
      primed_q <= primed_d;
      credit_q <= credit_d;
      prev_q   <= prev_d;
    end
  end

endmodule

### sv/tsdh_band.sv
`timescale 1ns / 1ps
// tsdh_band: hop timer, band snapshot rebuild and round-robin band pick
// depends on tsdh_pkg
module tsdh_band import tsdh_pkg::*; #(
  parameter int NUM_BANDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  cfg_t        cfg_i,
  input  logic [31:0] now_i,
  input  logic        changed_i,
  output band_res_t   res_o
);

  logic        selected_q;
  logic [3:0]  cur_q, cur_d;
  logic [15:0] snap_q, snap_d;
  logic        anchored_q;
  logic [31:0] last_q, last_d;
  logic        fb_q, fb_d;

  logic [15:0] limit, set, rot;
  logic [31:0] interval, elapsed;
  logic        do_hop;
  logic [3:0]  cur_r, step;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      limit[i] = (i < NUM_BANDS);
    end
  end

  always_comb begin
    interval = (cfg_i.hop_period == 32'd0) ? HOP_INTERVAL_DEFAULT
                                           : cfg_i.hop_period;
    elapsed  = now_i - last_q;
    do_hop   = anchored_q && cfg_i.hop_enable && (elapsed >= interval);
    last_d   = (!anchored_q || do_hop) ? now_i : last_q;

    // snapshot rebuild
    set    = cfg_i.band_enable_mask & limit;
    snap_d = snap_q;
    fb_d   = fb_q;
    cur_r  = cur_q;
    if (changed_i || !selected_q) begin
      fb_d = (set == 16'd0);
      if (set == 16'd0) begin
        set = 16'd1 << cfg_i.fallback_band;
      end
      snap_d = set;
      if (!(selected_q && set[cur_q])) begin
        cur_r = lowest_band(set);
      end
    end

    // next enabled band after the current one, wrapping around
    rot   = 16'({snap_d, snap_d} >> (5'(cur_r) + 5'd1));
    step  = lowest_band(rot);
    cur_d = cur_r;
    if (do_hop && rot != 16'd0) begin
      cur_d = cur_r + 4'd1 + step;
    end

    res_o.band          = cur_d;
    res_o.hopped        = do_hop;
    res_o.used_fallback = fb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      selected_q <= 1'b0;
      cur_q      <= '0;
      snap_q     <= '0;
      anchored_q <= 1'b0;
      last_q     <= '0;
      fb_q       <= 1'b0;
    end else if (adv_i) begin
      selected_q <= 1'b1;
      cur_q      <= cur_d;
      snap_q     <= snap_d;
      anchored_q <= 1'b1;
      last_q     <= last_d;
      fb_q       <= fb_d;
    end
  end

endmodule

### sv/tx_slot_duty_and_band_hop_unit.sv
`timescale 1ns / 1ps
// tx_slot_duty_and_band_hop_unit: top level with input beat register, duty and
// band units, result register and apb register file; depends on tsdh_pkg
// path: an accepted beat waits in the input beat register, then moves to the result
// register, which drives m_axis
// throughput: one beat per cycle, set by the single-pass logic between the
// input register and the result register; no stall unless m_axis backs up
// reset: asynchronous active low, clears all scheduler state and loads the
// register defaults; s_axis_tready is high as soon as reset is released
module tx_slot_duty_and_band_hop_unit import tsdh_pkg::*; #(
  parameter int NUM_BANDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slot beats in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] slot_time_sec
  input  logic        s_axis_tuser,   // [0] rebuild band snapshot request
  // slot decisions out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] transmit, [4:1] band, [5] hopped,
                                      // [6] used_fallback, [7] zero
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // register file
  cfg_t       cfg_q;
  logic       cfg_we;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_percent     <= DUTY_PERCENT_RST;
      cfg_q.hop_enable       <= HOP_ENABLE_RST;
      cfg_q.hop_period       <= HOP_PERIOD_RST;
      cfg_q.band_enable_mask <= BAND_ENABLE_MASK_RST;
      cfg_q.fallback_band    <= FALLBACK_BAND_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_DUTY_PERCENT:     cfg_q.duty_percent     <= pwdata[6:0];
        REG_HOP_ENABLE:       cfg_q.hop_enable       <= pwdata[0];
        REG_HOP_PERIOD:       cfg_q.hop_period       <= pwdata;
        REG_BAND_ENABLE_MASK: cfg_q.band_enable_mask <= pwdata[15:0];
        REG_FALLBACK_BAND:    cfg_q.fallback_band    <= pwdata[3:0];
        default: ;  // writes outside the map are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DUTY_PERCENT:     prdata = 32'(cfg_q.duty_percent);
      REG_HOP_ENABLE:       prdata = 32'(cfg_q.hop_enable);
      REG_HOP_PERIOD:       prdata = cfg_q.hop_period;
      REG_BAND_ENABLE_MASK: prdata = 32'(cfg_q.band_enable_mask);
      REG_FALLBACK_BAND:    prdata = 32'(cfg_q.fallback_band);
      default:              prdata = '0;
    endcase
  end

  // input beat register; adv moves a beat into the result register and
  // commits the scheduler state in the same edge
  logic        in_valid_q;
  logic [31:0] in_time_q;
  logic        in_chg_q;
  logic        out_valid_q;
  logic [7:0]  out_data_q;
  logic        adv;
  logic        s_acc;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_time_q <= s_axis_tdata;
      in_chg_q  <= s_axis_tuser;
    end
  end

  // duty decision and band choice for the beat held in the input register
  logic      tx;
  band_res_t band_res;

  tsdh_duty u_duty (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .duty_i (cfg_q.duty_percent),
    .tx_o   (tx)
  );

  tsdh_band #(
    .NUM_BANDS (NUM_BANDS)
  ) u_band (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .cfg_i     (cfg_q),
    .now_i     (in_time_q),
    .changed_i (in_chg_q),
    .res_o     (band_res)
  );

  // result register, holds while m_axis stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {1'b0, band_res.used_fallback, band_res.hopped, band_res.band, tx};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### tb/tb_tx_slot_duty_and_band_hop_unit.sv
`timescale 1ns / 1ps
// tb_tx_slot_duty_and_band_hop_unit: self-checking bench for the slot duty and band hop unit
// holds its own slot predictor, random stream stalls and apb setup; depends on tsdh_pkg
module tb_tx_slot_duty_and_band_hop_unit;
  import tsdh_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int REPORT_LIMIT  = 200;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_SLOTS   = 78;

  // one pending slot beat: payload, lead-in idle cycles, and a flag that holds it
  // back until every outstanding decision has come out
  typedef struct packed {
    logic [31:0] sec;
    logic        changed;
    logic [4:0]  gap;
    logic        drain;
  } slot_item_t;

  typedef struct packed {
    logic       transmit;
    logic [3:0] band;
    logic       hopped;
    logic       used_fallback;
  } slot_decision_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] slot_time_sec
  logic        s_axis_tuser  = 1'b0; // [0] rebuild band snapshot request
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [0] transmit, [4:1] band, [5] hopped,
                                     // [6] used_fallback, [7] zero
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  tx_slot_duty_and_band_hop_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // register image, tracks every apb write
  logic [6:0]  cfg_duty     = DUTY_PERCENT_RST;
  logic        cfg_hop_en   = HOP_ENABLE_RST;
  logic [31:0] cfg_interval = HOP_PERIOD_RST;
  logic [15:0] cfg_mask     = BAND_ENABLE_MASK_RST;
  logic [3:0]  cfg_fallback = FALLBACK_BAND_RST;

  // scheduler state of the predictor, at its reset values
  logic        band_chosen     = 1'b0;
  logic [3:0]  cur_band        = '0;
  logic [15:0] band_set        = '0;
  logic        hop_anchored    = 1'b0;
  logic [31:0] last_hop_sec    = '0;
  logic        duty_primed     = 1'b0;
  logic [9:0]  duty_credit     = '0;
  logic [6:0]  prev_duty       = '0;
  logic        fallback_active = 1'b0;

  slot_item_t     slot_backlog[$];
  slot_decision_t pending_decisions[$];
  slot_item_t     next_slot;
  slot_decision_t want;
  logic           have_slot  = 1'b0;
  logic           slot_taken = 1'b0;
  logic           tx_calm    = 1'b1;
  logic           rx_calm    = 1'b0;
  int             rx_wait    = 0;
  int             cycle_count = 0;
  int             err_count  = 0;
  int             n_slots    = 0;
  int             n_tx       = 0;
  int             n_hops     = 0;
  int             n_fallback = 0;
  int             n_settings = 0;

  // decision for one slot beat; advances the predictor state
  function automatic slot_decision_t decide_slot(input logic [31:0] now, input logic changed);
    slot_decision_t d;
    logic [31:0]    span;
    logic           hop_now;
    logic           tx_now;
    logic [15:0]    usable;
    logic [3:0]     probe;
    logic [3:0]     hop_target;
    logic           found;
    span    = (cfg_interval == '0) ? HOP_INTERVAL_DEFAULT : cfg_interval;
    hop_now = 1'b0;
    tx_now  = 1'b0;

    // a duty change (the first slot after reset counts) re-primes the credit
    if (cfg_duty != prev_duty) begin
      duty_primed = 1'b0;
      duty_credit = '0;
      prev_duty   = cfg_duty;
    end

    // first slot anchors the hop timer; elapsed time wraps at 32 bits
    if (!hop_anchored) begin
      last_hop_sec = now;
      hop_anchored = 1'b1;
    end else begin
      hop_now = cfg_hop_en && ((now - last_hop_sec) >= span);
    end

    // snapshot rebuild: keep the current band if still enabled, else lowest;
    // an empty mask leaves the fallback band alone in the snapshot
    if (changed || !band_chosen) begin
      usable          = cfg_mask;
      fallback_active = (usable == '0);
      if (fallback_active) usable = 16'd1 << cfg_fallback;
      band_set = usable;
      if (!(band_chosen && band_set[cur_band])) begin
        found = 1'b0;
        for (int i = 0; i < 16; i++) begin
          if (!found && band_set[i]) begin
            cur_band = 4'(i);
            found    = 1'b1;
          end
        end
      end
    end

    // round-robin step; a single-band snapshot lands on the same band
    if (hop_now) begin
      probe      = cur_band;
      hop_target = cur_band;
      found      = 1'b0;
      for (int k = 0; k < 16; k++) begin
        probe = probe + 4'd1;
        if (!found && band_set[probe]) begin
          hop_target = probe;
          found      = 1'b1;
        end
      end
      cur_band     = hop_target;
      last_hop_sec = now;
    end
    band_chosen = 1'b1;

    if (!duty_primed) begin
      if (cfg_duty != '0 && cfg_duty < DUTY_FULL) duty_credit = CREDIT_WRAP - 10'(cfg_duty);
      else if (cfg_duty >= DUTY_FULL) duty_credit = '0;
      duty_primed = 1'b1;
    end

    // duty at or above full always transmits, zero never does
    if (cfg_duty >= DUTY_FULL) begin
      tx_now = 1'b1;
    end else if (cfg_duty != '0) begin
      duty_credit = duty_credit + 10'(cfg_duty);
      if (duty_credit >= CREDIT_WRAP) begin
        duty_credit = duty_credit - CREDIT_WRAP;
        tx_now      = 1'b1;
      end
    end
    if (!tx_now && duty_credit > CREDIT_CAP) duty_credit = CREDIT_CAP;
    duty_credit[9] = 1'b0;

    d.transmit      = tx_now;
    d.band          = cur_band;
    d.hopped        = hop_now;
    d.used_fallback = fallback_active;
    return d;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d decisions outstanding", cycle_count,
               pending_decisions.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // sender: slot beats taken at the rising edge get their decision predicted
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pending_decisions.push_back(decide_slot(s_axis_tdata, s_axis_tuser));
      slot_taken = 1'b1;
      n_slots++;
    end
  end

  // sender: next beat goes out at the falling edge after its lead-in gap
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !slot_taken)) begin
      slot_taken = 1'b0;
      if (!have_slot && slot_backlog.size() != 0) begin
        next_slot = slot_backlog.pop_front();
        have_slot = 1'b1;
      end
      if (!have_slot) begin
        s_axis_tvalid <= 1'b0;
      end else if (next_slot.gap != '0) begin
        s_axis_tvalid <= 1'b0;
        next_slot.gap = next_slot.gap - 5'd1;
      end else if (next_slot.drain && pending_decisions.size() != 0) begin
        // hold off until the block has emptied out
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_slot.sec;
        s_axis_tuser  <= next_slot.changed;
        have_slot = 1'b0;
      end
    end
  end

  // receiver: stall count drawn after every result beat
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_wait != 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: each result beat against the oldest predicted decision
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_decisions.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("%0t: result beat %h with no decision expected", $time, m_axis_tdata);
      end else begin
        want = pending_decisions.pop_front();
        if (want.transmit      !== m_axis_tdata[0]   ||
            want.band          !== m_axis_tdata[4:1] ||
            want.hopped        !== m_axis_tdata[5]   ||
            want.used_fallback !== m_axis_tdata[6]) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("%0t: expected tx=%0b band=%0d hop=%0b fb=%0b, got tx=%0b band=%0d hop=%0b fb=%0b",
                     $time, want.transmit, want.band, want.hopped, want.used_fallback,
                     m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[5], m_axis_tdata[6]);
        end
        n_tx       += int'(want.transmit);
        n_hops     += int'(want.hopped);
        n_fallback += int'(want.used_fallback);
      end
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      rx_wait = (rx_calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    end
  end

  task automatic queue_slot(input logic [31:0] sec, input logic changed, input logic drain);
    slot_item_t it;
    it.sec     = sec;
    it.changed = changed;
    it.drain   = drain;
    it.gap     = (tx_calm || $urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(0, 17));
    slot_backlog.push_back(it);
  endtask

  // wait for an empty pipe, then the block latency and some margin
  task automatic settle();
    do @(negedge clk_i);
    while (slot_backlog.size() != 0 || have_slot || s_axis_tvalid ||
           pending_decisions.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // apb write: setup cycle, access cycle, register image follows
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i);
    while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_DUTY_PERCENT:     cfg_duty     = val[6:0];
      REG_HOP_ENABLE:       cfg_hop_en   = val[0];
      REG_HOP_PERIOD:       cfg_interval = val;
      REG_BAND_ENABLE_MASK: cfg_mask     = val[15:0];
      REG_FALLBACK_BAND:    cfg_fallback = val[3:0];
      default: ;
    endcase
  endtask

  initial begin
    logic [31:0] sec;
    logic [31:0] span;
    int          drain_at;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, hop timer off: first slot anchors and builds the snapshot,
    // time extremes pass without a hop
    queue_slot(32'h0000_0000, 1'b0, 1'b0);
    queue_slot(32'h0000_0025, 1'b1, 1'b0);
    queue_slot(32'hFFFF_FFFF, 1'b0, 1'b1);
    settle();

    // hops on a single band, interval zero read as default, duty above full,
    // elapsed time across the 32-bit wrap
    write_reg(REG_HOP_ENABLE, 32'd1);
    write_reg(REG_HOP_PERIOD, 32'd0);
    write_reg(REG_DUTY_PERCENT, 32'd127);
    n_settings++;
    queue_slot(32'hFFFF_FFF0, 1'b0, 1'b0);
    queue_slot(32'h0000_0050, 1'b0, 1'b0);
    queue_slot(32'h0000_0068, 1'b0, 1'b0);
    settle();

    // empty mask falls back to the highest band, duty zero never sends
    write_reg(REG_BAND_ENABLE_MASK, 32'h0);
    write_reg(REG_FALLBACK_BAND, 32'd15);
    write_reg(REG_DUTY_PERCENT, 32'd0);
    n_settings++;
    queue_slot(32'h0000_0100, 1'b1, 1'b0);
    queue_slot(32'h0000_0101, 1'b0, 1'b0);
    settle();

    // all bands, one-second hops: rebuild keeps band 15, then wraps round
    write_reg(REG_BAND_ENABLE_MASK, 32'hFFFF);
    write_reg(REG_HOP_PERIOD, 32'd1);
    write_reg(REG_DUTY_PERCENT, 32'd33);
    n_settings++;
    queue_slot(32'h0000_0200, 1'b1, 1'b0);
    queue_slot(32'h0000_0201, 1'b0, 1'b0);
    queue_slot(32'h0000_0202, 1'b0, 1'b0);
    queue_slot(32'h0000_0202, 1'b0, 1'b0);
    queue_slot(32'h0000_0203, 1'b1, 1'b0);
    settle();

    // sparse mask drops the current band, longest interval fires on full wrap
    write_reg(REG_DUTY_PERCENT, 32'd100);
    write_reg(REG_HOP_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_BAND_ENABLE_MASK, 32'hA5A5);
    write_reg(REG_FALLBACK_BAND, 32'd0);
    n_settings++;
    queue_slot(32'h0000_0300, 1'b1, 1'b0);
    queue_slot(32'h0000_0202, 1'b0, 1'b0);
    settle();

    // lowest and highest partial duty with hops off
    write_reg(REG_HOP_ENABLE, 32'd0);
    write_reg(REG_DUTY_PERCENT, 32'd1);
    n_settings++;
    for (int i = 0; i < 3; i++) queue_slot(32'h0000_0400 + i, 1'b0, 1'b0);
    settle();
    write_reg(REG_DUTY_PERCENT, 32'd99);
    n_settings++;
    for (int i = 0; i < 3; i++) queue_slot(32'h0000_0500 + i, 1'b0, 1'b0);

    // random settings, slot streams that often step near the hop interval
    sec = 32'h0000_1000;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       write_reg(REG_DUTY_PERCENT, 32'd0);
          1:       write_reg(REG_DUTY_PERCENT, 32'd100);
          2:       write_reg(REG_DUTY_PERCENT, 32'd127);
          3:       write_reg(REG_DUTY_PERCENT, 32'd1);
          4:       write_reg(REG_DUTY_PERCENT, 32'd99);
          5:       write_reg(REG_DUTY_PERCENT, $urandom_range(101, 127));
          default: write_reg(REG_DUTY_PERCENT, $urandom_range(0, 100));
        endcase
      end
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_HOP_ENABLE, 32'($urandom_range(0, 3) != 0));
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(REG_HOP_PERIOD, 32'd0);
          1:       write_reg(REG_HOP_PERIOD, 32'd1);
          2:       write_reg(REG_HOP_PERIOD, 32'hFFFF_FFFF);
          3:       write_reg(REG_HOP_PERIOD, $urandom);
          default: write_reg(REG_HOP_PERIOD, $urandom_range(2, 150));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 4))
          0:       write_reg(REG_BAND_ENABLE_MASK, 32'h0);
          1:       write_reg(REG_BAND_ENABLE_MASK, 32'hFFFF);
          2:       write_reg(REG_BAND_ENABLE_MASK, 32'd1 << $urandom_range(0, 15));
          3:       write_reg(REG_BAND_ENABLE_MASK, $urandom & $urandom);
          default: write_reg(REG_BAND_ENABLE_MASK, $urandom);
        endcase
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_FALLBACK_BAND, $urandom);
      n_settings++;

      tx_calm  = ($urandom_range(0, 3) == 0);
      drain_at = $urandom_range(0, PHASE_SLOTS - 1);
      span     = (cfg_interval == '0) ? HOP_INTERVAL_DEFAULT : cfg_interval;
      for (int n = 0; n < PHASE_SLOTS; n++) begin
        case ($urandom_range(0, 9))
          0:       sec = $urandom;
          1:       ;
          2, 3, 4: sec = sec + $urandom_range(1, 5);
          5, 6, 7, 8: sec = sec + span + 32'($urandom_range(0, 2)) - 32'd1;
          default: sec = sec + $urandom_range(0, 1000);
        endcase
        queue_slot(sec, $urandom_range(0, 7) == 0, n == drain_at);
      end
    end
    settle();

    $display("covered %0d slot beats over %0d register settings", n_slots, n_settings);
    $display("decisions seen: %0d transmit, %0d hop, %0d on fallback", n_tx, n_hops, n_fallback);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
